FILE: hdl/sdq_pkg.sv
package sdq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int POP_W       = $clog2(MAX_RESULTS);

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_FULL    = 1'b1;

  typedef logic [TIME_BITS-1:0] qtime_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic        func;
    logic [47:0] due_time;
    logic [31:0] tag;
    logic [47:0] now_time;
  } sdq_in_t;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic [31:0] out_tag;
    logic [47:0] out_time;
    logic [5:0]  entry_count;
    logic        last;
  } sdq_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_TICK
  } sdq_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic insert;
    logic pop;
    logic load_res;
    logic res_kind;
    logic res_last;
  } sdq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic head_due;
    logic next_due;
    logic out_free;
  } sdq_stat_t;

  // Bring a port time into the queue's time width.
  function automatic qtime_t to_qtime(logic [47:0] t);
    return TIME_BITS'(t);
  endfunction

endpackage

FILE: hdl/sdq_datapath.sv
module sdq_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sdq_pkg::sdq_in_t  in_data,
  input  sdq_pkg::sdq_cmd_t cmd,
  input  logic              out_stall,
  output sdq_pkg::sdq_stat_t stat,
  output logic              out_valid,
  output sdq_pkg::sdq_out_t out_data
);
  import sdq_pkg::*;

  qtime_t      slot_time_r [QUEUE_DEPTH];
  logic [31:0] slot_tag_r  [QUEUE_DEPTH];
  cnt_t        count_r, count_nxt;
  sdq_in_t     item_r;
  sdq_out_t    res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;

  qtime_t      due_q, now_q;
  logic [QUEUE_DEPTH-1:0] le;
  logic        full;

  assign due_q = to_qtime(item_r.due_time);
  assign now_q = to_qtime(item_r.now_time);
  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));

  // Thermometer of held slots at or before the new due time.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count_r) && (slot_time_r[i] <= due_q);
    end
  end

  always_comb begin
    stat.head_due = (count_r != '0) && (slot_time_r[0] <= now_q);
    stat.next_due = (count_r > CNT_W'(1)) && (slot_time_r[1] <= now_q);
    stat.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.insert && !full) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!le[i]) begin
          if (i == 0) begin
            slot_time_r[i] <= due_q;
            slot_tag_r[i]  <= item_r.tag;
          end else if (le[i-1]) begin
            slot_time_r[i] <= due_q;
            slot_tag_r[i]  <= item_r.tag;
          end else begin
            slot_time_r[i] <= slot_time_r[i-1];
            slot_tag_r[i]  <= slot_tag_r[i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_time_r[i] <= slot_time_r[i+1];
        slot_tag_r[i]  <= slot_tag_r[i+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.load_res) begin
      res_nxt.kind        = cmd.res_kind;
      res_nxt.entry_count = 6'(count_nxt);
      res_nxt.last        = cmd.res_last;
      if (cmd.res_kind == KIND_EXPIRED) begin
        res_nxt.status   = STAT_OK;
        res_nxt.out_tag  = slot_tag_r[0];
        res_nxt.out_time = 48'(slot_time_r[0]);
      end else begin
        res_nxt.status   = full ? STAT_FULL : STAT_OK;
        res_nxt.out_tag  = '0;
        res_nxt.out_time = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_res) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0) && stat.head_due)
    else $error("pop without a due head entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_res |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_insert_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !cmd.pop)
    else $error("insert and pop in one cycle");

endmodule

FILE: hdl/sdq_ctrl.sv
module sdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_func,
  input  sdq_pkg::sdq_stat_t stat,
  output logic               in_stall,
  output sdq_pkg::sdq_cmd_t  cmd
);
  import sdq_pkg::*;

  sdq_state_t       state_r, state_nxt;
  logic [POP_W-1:0] pop_cnt_r, pop_cnt_nxt;
  logic             tick_last;

  // Close the burst when nothing more is due or the per-tick limit is hit.
  assign tick_last = !stat.next_due || (pop_cnt_r == POP_W'(MAX_RESULTS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == FUNC_TICK) ? ST_TICK : ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (!stat.head_due) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free && tick_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    pop_cnt_nxt = pop_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        pop_cnt_nxt = '0;
      end
      ST_INSERT: begin
        if (stat.out_free) begin
          cmd.insert   = 1'b1;
          cmd.load_res = 1'b1;
          cmd.res_kind = KIND_STATUS;
          cmd.res_last = 1'b1;
        end
      end
      ST_TICK: begin
        if (stat.head_due && stat.out_free) begin
          cmd.pop      = 1'b1;
          cmd.load_res = 1'b1;
          cmd.res_kind = KIND_EXPIRED;
          cmd.res_last = tick_last;
          pop_cnt_nxt  = pop_cnt_r + POP_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pop_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pop_cnt_r <= pop_cnt_nxt;
    end
  end

endmodule

FILE: hdl/sorted_delay_queue.sv
// Time-ordered queue of up to 32 pending entries (due time, tag). An insert
// item places the entry behind every held entry with an earlier or equal due
// time, so equal times leave first in, first out, and answers with one status
// item: accepted, or full with the entry dropped. A tick item carries the
// current time and pops every entry at the head that is due, one result item
// per entry with last set on the final one; at most 32 leave per tick and a
// tick with nothing due gives no result. Every result reports the entry count
// left behind. One item is worked at a time: an insert is accepted, then placed by
// one parallel compare-and-shift over all slots; a tick is accepted, then pops
// each due entry by one shift of the slot row; a tick with nothing due is
// accepted, then ends at the head check. Downstream stall holds an insert or a
// pop until the result register is free. Slot contents are not cleared by
// reset; only the entry count is.
module sorted_delay_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdq_pkg::sdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sdq_pkg::sdq_out_t out_data
);
  import sdq_pkg::*;

  sdq_cmd_t  cmd;
  sdq_stat_t stat;

  // Sequence inserts and tick bursts.
  sdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Hold the sorted slot row, the entry count and the result register.
  sdq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
